[src/pafk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pafk_pkg
// Shared widths, constants and CORDIC tables for the planar arm block.
// ----------------------------------------------------------------------------
package pafk_pkg;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int NUM_STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int STEP_W = $clog2(ATAN_ENTRIES);   // cell step index
   localparam int CW = 34;               // CORDIC datapath width
   localparam int ZW = 33;
   localparam int LEN_W = 16;
   localparam int ANG_W = 16;
   localparam int POS_W = 19;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [1:0] CSR_LINK_ONE   = 2'd0;
   localparam logic [1:0] CSR_LINK_TWO   = 2'd1;
   localparam logic [1:0] CSR_LINK_THREE = 2'd2;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 flip;
   } rot_type;

   typedef struct packed {
      rot_type              r1;
      rot_type              r2;
      rot_type              r3;
      logic [ANG_W-1:0]     heading;
   } cell_type;

   function automatic logic signed [ZW-1:0] atan_of(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
         3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
         9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
         12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
         15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
         18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
         21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
         default: t = 32'h0;
      endcase
      return $signed({1'b0, t});
   endfunction

   function automatic rot_type rot_init(input logic [ANG_W-1:0] a);
      rot_type r;
      logic [31:0] zu;
      zu = {a, 16'h0000};
      r.flip = zu[31] ^ zu[30];
      if (r.flip) zu = zu + 32'h80000000;
      r.x = CORDIC_GAIN;
      r.y = '0;
      r.z = $signed({zu[31], zu});
      return r;
   endfunction

   function automatic rot_type rot_step(input rot_type r, input int i);
      rot_type o;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      dx = r.y >>> i;
      dy = r.x >>> i;
      o = r;
      if (!r.z[ZW-1]) begin
         o.x = r.x - dx; o.y = r.y + dy; o.z = r.z - atan_of(i);
      end else begin
         o.x = r.x + dx; o.y = r.y - dy; o.z = r.z + atan_of(i);
      end
      return o;
   endfunction
endpackage

[src/pafk_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pafk_cell
// One CORDIC micro-rotation for all three headings, registered.
// ----------------------------------------------------------------------------
module pafk_cell import pafk_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [STEP_W-1:0] step,     // tied to the cell's place in the chain
   input  cell_type          cell_in,
   output cell_type          cell_out
);
   cell_type cell_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff.r1      <= rot_step(cell_in.r1, int'(step));
         cell_ff.r2      <= rot_step(cell_in.r2, int'(step));
         cell_ff.r3      <= rot_step(cell_in.r3, int'(step));
         cell_ff.heading <= cell_in.heading;
      end
   end
   assign cell_out = cell_ff;
endmodule

[src/pafk_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pafk_scale
// Link-length products, rounding and position sums (three stages).
// ----------------------------------------------------------------------------
module pafk_scale import pafk_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  cell_type          cell_in,
   input  logic [LEN_W-1:0]  len1,
   input  logic [LEN_W-1:0]  len2,
   input  logic [LEN_W-1:0]  len3,
   output logic [6*POS_W+ANG_W-1:0] result
);
   localparam int PW = CW + LEN_W + 1;
   logic signed [PW-1:0] p_ff [6];
   logic [ANG_W-1:0] h1_ff, h2_ff, h3_ff;
   logic signed [POS_W-1:0] t_ff [6];
   logic signed [POS_W-1:0] o_ff [6];

   function automatic logic signed [CW-1:0] fl(input logic signed [CW-1:0] v, input logic f);
      return f ? -v : v;
   endfunction

   function automatic logic signed [POS_W-1:0] rnd(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = (p + (PW'(1) <<< 29)) >>> 30;
      return s[POS_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff[0] <= $signed({1'b0, len1}) * fl(cell_in.r1.x, cell_in.r1.flip);
         p_ff[1] <= $signed({1'b0, len1}) * fl(cell_in.r1.y, cell_in.r1.flip);
         p_ff[2] <= $signed({1'b0, len2}) * fl(cell_in.r2.x, cell_in.r2.flip);
         p_ff[3] <= $signed({1'b0, len2}) * fl(cell_in.r2.y, cell_in.r2.flip);
         p_ff[4] <= $signed({1'b0, len3}) * fl(cell_in.r3.x, cell_in.r3.flip);
         p_ff[5] <= $signed({1'b0, len3}) * fl(cell_in.r3.y, cell_in.r3.flip);
         h1_ff <= cell_in.heading;
         for (int i = 0; i < 6; i++) t_ff[i] <= rnd(p_ff[i]);
         h2_ff <= h1_ff;
         o_ff[0] <= t_ff[0];
         o_ff[1] <= t_ff[1];
         o_ff[2] <= t_ff[0] + t_ff[2];
         o_ff[3] <= t_ff[1] + t_ff[3];
         o_ff[4] <= t_ff[0] + t_ff[2] + t_ff[4];
         o_ff[5] <= t_ff[1] + t_ff[3] + t_ff[5];
         h3_ff <= h2_ff;
      end
   end
   assign result = {h3_ff, o_ff[5], o_ff[4], o_ff[3], o_ff[2], o_ff[1], o_ff[0]};
endmodule

[src/planar_arm_forward_kinematics.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_arm_forward_kinematics
// Three-link planar arm: joint angles in, joint positions and heading out.
// ----------------------------------------------------------------------------
// Usage:
//  req_ beats carry three 16-bit binary angles; rsp_ beats carry elbow, wrist
//  and tip coordinates (Q10.8) plus the tip heading. csr_ writes set the link
//  lengths (Q8.8, index 0..2); write only while the pipe is empty.
//  Throughput: one beat per cycle while the output is not stalled. Pipeline:
//  1 entry stage + NUM_STEPS CORDIC cells + 3 scaling stages.
//  The whole pipe advances together; when rsp_tready is low and the output
//  holds a beat, the pipe freezes and req_tready stays low for as long as
//  that beat waits, even if earlier stages only hold bubbles.
//  Reset clears all valid bits and restores default link lengths.
// ----------------------------------------------------------------------------
module planar_arm_forward_kinematics import pafk_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] joint_one_angle, [31:16] joint_two_angle, [47:32] joint_three_angle
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // elbow_x, elbow_y, wrist_x, wrist_y, tip_x, tip_y (19 b each), tip_heading
   output logic [135:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int DEPTH = NUM_STEPS + 4;

   logic [LEN_W-1:0] len1_ff, len2_ff, len3_ff;
   logic [DEPTH-1:0] vld_ff;
   logic             advance;
   cell_type         chain [NUM_STEPS+1];
   cell_type         entry_ff;
   logic [ANG_W-1:0] a1, a2, a3;

   // freeze the pipe only when the output beat is stuck
   assign advance    = !(vld_ff[DEPTH-1] && !rsp_tready);
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len1_ff <= 16'd25600; len2_ff <= 16'd19200; len3_ff <= 16'd12800;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LINK_ONE:   len1_ff <= csr_data;
            CSR_LINK_TWO:   len2_ff <= csr_data;
            CSR_LINK_THREE: len3_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
   end

   assign a1 = req_tdata[15:0];
   assign a2 = req_tdata[31:16];
   assign a3 = req_tdata[47:32];

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff.r1      <= rot_init(a1);
         entry_ff.r2      <= rot_init(a1 + a2);
         entry_ff.r3      <= rot_init(a1 + a2 + a3);
         entry_ff.heading <= a1 + a2 + a3;
      end
   end
   assign chain[0] = entry_ff;

   for (genvar g = 0; g < NUM_STEPS; g++) begin : g_cell
      pafk_cell u_cell (
         .clock(clock), .enable(advance), .step(STEP_W'(g)),
         .cell_in(chain[g]), .cell_out(chain[g+1])
      );
   end

   pafk_scale u_scale (
      .clock(clock), .enable(advance), .cell_in(chain[NUM_STEPS]),
      .len1(len1_ff), .len2(len2_ff), .len3(len3_ff), .result(rsp_tdata[129:0])
   );
   assign rsp_tdata[135:130] = '0;
   assign rsp_tvalid = vld_ff[DEPTH-1];
endmodule

[src/pafk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pafk_checker
// Port-level checks for the planar arm block.
// ----------------------------------------------------------------------------
module pafk_checker (
   input logic clock, input logic reset,
   input logic req_tready,
   input logic rsp_tvalid, input logic rsp_tready,
   input logic [135:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("stall without output");
   a_pad: assert property (@(posedge clock) rsp_tdata[135:130] == 6'd0)
      else $error("pad bits set");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("valid after reset");
endmodule

bind planar_arm_forward_kinematics pafk_checker u_chk (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

[tb/planar_arm_forward_kinematics_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_arm_forward_kinematics_tb
// Self-checking bench for the three-link arm kinematics block. Angle beats
// come from a directed table and then from random traffic. Each beat is run
// through a local CORDIC model of the block. Response beats are compared field
// by field with the oldest queued pose. Link lengths are changed between
// phases, only while the pipe is drained.
// ----------------------------------------------------------------------------
module planar_arm_forward_kinematics_tb;
   import pafk_pkg::*;

   localparam int PIPE_LAT  = NUM_STEPS + 4;
   localparam int WDOG_MAX  = 4000;

   typedef struct packed {
      logic [15:0] heading;
      logic [18:0] tip_y;
      logic [18:0] tip_x;
      logic [18:0] wrist_y;
      logic [18:0] wrist_x;
      logic [18:0] elbow_y;
      logic [18:0] elbow_x;
   } pose_type;

   typedef struct {
      logic [15:0] a1, a2, a3;
      bit          fixed;     // expected pose typed into the row
      pose_type    pose;
   } angle_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   // link lengths as the model sees them
   logic [15:0]  len_one = 16'd25600, len_two = 16'd19200, len_three = 16'd12800;
   pose_type     pose_q[$];
   int           errors = 0;
   int           idle_cycles = 0;
   bit           stall_mode = 1'b0;   // 0 random backpressure, 1 always ready
   bit           hold_off = 1'b0;

   always #6 clock = ~clock;

   planar_arm_forward_kinematics u_top (.*);

   // ---- predictor --------------------------------------------------------
   // 64-bit signed floor shift; >>> on a signed longint is arithmetic (floor).
   function automatic void sincos(input logic [15:0] ang,
                                  output longint cs, output longint sn);
      logic [31:0] zu;
      bit          flip;
      longint      x, y, z, dx, dy, at;
      zu   = {ang, 16'h0};
      flip = zu[31] ^ zu[30];
      if (flip) zu = zu + 32'h8000_0000;
      z = longint'($signed(zu));
      x = 652032874;
      y = 0;
      for (int i = 0; i < NUM_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         at = longint'(atan_of(i));
         if (z >= 0) begin
            x -= dx; y += dy; z -= at;
         end else begin
            x += dx; y -= dy; z += at;
         end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endfunction

   function automatic longint link_term(input logic [15:0] len, input longint f);
      return (longint'(len) * f + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic pose_type arm_pose(input logic [15:0] a1, a2, a3);
      pose_type p;
      longint c, s, x, y;
      logic [15:0] h2, h3;
      h2 = a1 + a2;
      h3 = a1 + a2 + a3;
      sincos(a1, c, s);
      x = link_term(len_one, c); y = link_term(len_one, s);
      p.elbow_x = x[18:0]; p.elbow_y = y[18:0];
      sincos(h2, c, s);
      x += link_term(len_two, c); y += link_term(len_two, s);
      p.wrist_x = x[18:0]; p.wrist_y = y[18:0];
      sincos(h3, c, s);
      x += link_term(len_three, c); y += link_term(len_three, s);
      p.tip_x = x[18:0]; p.tip_y = y[18:0];
      p.heading = h3;
      return p;
   endfunction

   // ---- driver tasks -----------------------------------------------------
   // req_tvalid stays high after a beat; it drops before a gap or in drain.
   task automatic send_angles(input logic [15:0] a1, a2, a3, input bit gaps);
      int gap;
      gap = 0;
      if (gaps) begin
         // mostly short gaps, now and then a long one
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {a3, a2, a1};
      pose_q.push_back(arm_pose(a1, a2, a3));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_len(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LINK_ONE:   len_one   = val;
         CSR_LINK_TWO:   len_two   = val;
         CSR_LINK_THREE: len_three = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pose_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   // ---- response side ----------------------------------------------------
   // Backpressure: random stalls or always ready, or one long hold while the sender keeps going.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (stall_mode) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 9) < 7);
      end
   end

   initial begin
      #1;
      forever begin
         @(posedge clock);
         if (!reset && $urandom_range(0, 2) == 0 && $urandom_range(0, 399) == 0)
            stall_mode = ~stall_mode;
      end
   end

   // Scoreboard: sample on the edge, compare against the oldest pose.
   always @(posedge clock) begin
      pose_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = pose_type'(rsp_tdata[129:0]);
         if (pose_q.size() == 0) begin
            $error("response beat with no pose pending");
            errors++;
         end else begin
            want = pose_q.pop_front();
            if (got.elbow_x !== want.elbow_x) begin
               $error("elbow_x expected %0h got %0h", want.elbow_x, got.elbow_x); errors++;
            end
            if (got.elbow_y !== want.elbow_y) begin
               $error("elbow_y expected %0h got %0h", want.elbow_y, got.elbow_y); errors++;
            end
            if (got.wrist_x !== want.wrist_x) begin
               $error("wrist_x expected %0h got %0h", want.wrist_x, got.wrist_x); errors++;
            end
            if (got.wrist_y !== want.wrist_y) begin
               $error("wrist_y expected %0h got %0h", want.wrist_y, got.wrist_y); errors++;
            end
            if (got.tip_x !== want.tip_x) begin
               $error("tip_x expected %0h got %0h", want.tip_x, got.tip_x); errors++;
            end
            if (got.tip_y !== want.tip_y) begin
               $error("tip_y expected %0h got %0h", want.tip_y, got.tip_y); errors++;
            end
            if (got.heading !== want.heading) begin
               $error("tip_heading expected %0h got %0h", want.heading, got.heading);
               errors++;
            end
         end
      end
   end

   // Watchdog: cycles with no beat accepted on any channel, outside the long hold.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready) || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---- stimulus ---------------------------------------------------------
   // Directed rows. With zero lengths every coordinate is zero and only the
   // heading (wrapped angle sum) remains, so those rows carry typed results.
   angle_row_type dir_rows[] = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
      '{16'h4000, 16'h0000, 16'h0000, 1'b0, '0},   // quarter turn, flip edge
      '{16'h8000, 16'h0000, 16'h0000, 1'b0, '0},   // half turn
      '{16'hC000, 16'h0000, 16'h0000, 1'b0, '0},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0},
      '{16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
      '{16'hFFFF, 16'h0001, 16'hFFFF, 1'b0, '0},
      '{16'h3FFF, 16'h0001, 16'h4000, 1'b0, '0},
      '{16'hBFFF, 16'h8001, 16'h7FFF, 1'b0, '0},
      '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0},
      '{16'h2000, 16'h2000, 16'h2000, 1'b0, '0},
      '{16'hE000, 16'hE000, 16'hE000, 1'b0, '0}
   };
   angle_row_type zero_rows[] = '{
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, '{heading: 16'h7FFD, default: '0}},
      '{16'h8000, 16'h8000, 16'h8000, 1'b1, '{heading: 16'h8000, default: '0}},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{heading: 16'hFFFD, default: '0}}
   };

   task automatic run_rows(input angle_row_type rows[]);
      pose_type p;
      foreach (rows[i]) begin
         if (rows[i].fixed) begin
            p = arm_pose(rows[i].a1, rows[i].a2, rows[i].a3);
            if (p !== rows[i].pose) begin
               $error("typed pose row %0d expected %0h got %0h", i, rows[i].pose, p);
               errors++;
            end
         end
         send_angles(rows[i].a1, rows[i].a2, rows[i].a3, 1'b1);
      end
   endtask

   task automatic random_burst(input int n);
      for (int i = 0; i < n; i++)
         send_angles(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b1);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset lengths first
      run_rows(dir_rows);
      drain();

      // extremes: all zero, then all maximum
      write_len(CSR_LINK_ONE, 16'h0000);
      write_len(CSR_LINK_TWO, 16'h0000);
      write_len(CSR_LINK_THREE, 16'h0000);
      run_rows(zero_rows);
      drain();
      write_len(CSR_LINK_ONE, 16'hFFFF);
      write_len(CSR_LINK_TWO, 16'hFFFF);
      write_len(CSR_LINK_THREE, 16'hFFFF);
      run_rows(dir_rows);
      random_burst(100);
      drain();

      // long receiver hold while the sender keeps offering: pipe fills up
      fork
         begin
            hold_off = 1'b1;
            repeat (PIPE_LAT * 4) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 60; i++)
            send_angles(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
      join
      drain();

      // several random length settings, each with a random burst
      for (int ph = 0; ph < 6; ph++) begin
         write_len(CSR_LINK_ONE, 16'($urandom()));
         write_len(CSR_LINK_TWO, 16'($urandom()));
         write_len(CSR_LINK_THREE, 16'($urandom()));
         random_burst(190);
         drain();
      end

      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

[filelist.f]
src/pafk_pkg.sv
src/pafk_cell.sv
src/pafk_scale.sv
src/planar_arm_forward_kinematics.sv
src/pafk_checker.sv
tb/planar_arm_forward_kinematics_tb.sv
